FILE: rtl/fdcf_pkg.sv
// ----------------------------------------------------------------------------
// fdcf_pkg
// Shared widths, register codes and saturation helper for the fractional
// delay comb filter.
// ----------------------------------------------------------------------------
package fdcf_pkg;

  localparam int MAX_DELAY    = 4096;
  localparam int SAMPLE_WIDTH = 16;

  localparam int ADDR_W     = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int CNT_W      = $clog2(MAX_DELAY + 1);
  localparam int DLEN_W     = 13;
  localparam int FRAC_W     = 17;
  localparam int GAIN_W     = 16;
  localparam int GAIN_SHIFT = 14;
  localparam int FRAC_SHIFT = 16;
  localparam int LEN_W      = (DLEN_W > CNT_W) ? DLEN_W : CNT_W;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = FRAC_W;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  // interpolation: sample times 18-bit signed weight, sum of two
  localparam int PROD_W = SAMPLE_WIDTH + FRAC_W + 1;
  localparam int ACC_W  = PROD_W + 1;
  // gain products and pre-saturation sums
  localparam int GPROD_W = SAMPLE_WIDTH + GAIN_W;
  localparam int GTERM_W = GPROD_W - GAIN_SHIFT;
  localparam int WIDE_W  = GTERM_W + 1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [ADDR_W-1:0]              addr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LENGTH     = CFG_IDX_W'(0),
    CFG_INTERP_FRAC      = CFG_IDX_W'(1),
    CFG_FEEDFORWARD_GAIN = CFG_IDX_W'(2),
    CFG_FEEDBACK_GAIN    = CFG_IDX_W'(3)
  } cfg_idx_t;

  function automatic sample_t saturate(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    lo = -hi - WIDE_W'(1);
    if (v > hi) begin
      return sample_t'(hi);
    end else if (v < lo) begin
      return sample_t'(lo);
    end
    return v[SAMPLE_WIDTH-1:0];
  endfunction

endpackage

FILE: rtl/fdcf_ram.sv
// ----------------------------------------------------------------------------
// fdcf_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module fdcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                      rdata_a,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                      rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/fractional_delay_comb_filter.sv
// ----------------------------------------------------------------------------
// fractional_delay_comb_filter
// Comb filter with linearly interpolated delay taps read from a circular
// delay RAM; feedback subtracted from the input, feedforward added at output.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_sample
//   out_     output     out_valid/out_ready  out_sample
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each item steps through tap read, interpolation multiply, sum, gain
// multiply and write-back before the next sample can be taken.
// The delay RAM read-modify-write sequence sets this order.
// After reset the RAM reads as zero through a fill count; no clearing pass.
// A result waiting in the output register stalls only the write-back step.
// ----------------------------------------------------------------------------
module fractional_delay_comb_filter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [fdcf_pkg::SAMPLE_WIDTH-1:0] in_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [fdcf_pkg::SAMPLE_WIDTH-1:0] out_sample,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fdcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fdcf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import fdcf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_INTERP,
    S_SUM,
    S_GAIN,
    S_DONE
  } state_t;

  state_t state_r;

  logic [DLEN_W-1:0]        delay_length_r;
  logic [FRAC_W-1:0]        interp_frac_r;
  logic signed [GAIN_W-1:0] ff_gain_r;
  logic signed [GAIN_W-1:0] fb_gain_r;

  addr_t             wp_r;
  logic [CNT_W-1:0]  fill_r;
  addr_t             far_addr_r;
  addr_t             near_addr_r;
  logic              far_ok_r;
  logic              near_ok_r;
  sample_t           x_r;
  logic [FRAC_W-1:0] frac_r;
  logic signed [PROD_W-1:0] p_far_r;
  logic signed [PROD_W-1:0] p_near_r;
  sample_t           d_r;
  logic signed [GPROD_W-1:0] fb_prod_r;
  logic signed [GPROD_W-1:0] ff_prod_r;
  logic              out_valid_r;
  sample_t           out_sample_r;

  // tap addressing at transfer
  logic [LEN_W-1:0] dl_ext;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] near_k;
  logic [FRAC_W-1:0] frac_clamped;
  addr_t far_addr_nxt;
  addr_t near_addr_nxt;
  addr_t wp_nxt;

  function automatic addr_t tap_addr(input addr_t wp, input logic [CNT_W-1:0] k);
    logic [CNT_W-1:0] km;
    logic [CNT_W:0]   sum;
    km = (k == CNT_W'(MAX_DELAY)) ? '0 : k;
    if ({1'b0, wp} >= km) begin
      sum = (CNT_W+1)'({1'b0, wp}) - (CNT_W+1)'(km);
    end else begin
      sum = (CNT_W+1)'({1'b0, wp}) + (CNT_W+1)'(MAX_DELAY) - (CNT_W+1)'(km);
    end
    return sum[ADDR_W-1:0];
  endfunction

  always_comb begin
    dl_ext = LEN_W'(delay_length_r);
    if (dl_ext == '0) begin
      len = CNT_W'(1);
    end else if (dl_ext > LEN_W'(MAX_DELAY)) begin
      len = CNT_W'(MAX_DELAY);
    end else begin
      len = dl_ext[CNT_W-1:0];
    end
    near_k = (len > CNT_W'(1)) ? len - CNT_W'(1) : CNT_W'(1);
    frac_clamped = (interp_frac_r > FRAC_ONE) ? FRAC_ONE : interp_frac_r;
    far_addr_nxt  = tap_addr(wp_r, len);
    near_addr_nxt = tap_addr(wp_r, near_k);
    wp_nxt = (wp_r == addr_t'(MAX_DELAY - 1)) ? '0 : wp_r + addr_t'(1);
  end

  // RAM
  sample_t rd_far;
  sample_t rd_near;
  logic    ram_we;
  sample_t u_val;

  fdcf_ram #(
    .WIDTH(SAMPLE_WIDTH),
    .DEPTH(MAX_DELAY)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (wp_r),
    .wdata  (u_val),
    .raddr_a(far_addr_r),
    .rdata_a(rd_far),
    .raddr_b(near_addr_r),
    .rdata_b(rd_near)
  );

  // datapath
  sample_t far_v;
  sample_t near_v;
  logic [FRAC_W-1:0] w_near;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [GTERM_W-1:0] fb_term;
  logic signed [GTERM_W-1:0] ff_term;
  logic signed [WIDE_W-1:0]  u_wide;
  logic signed [WIDE_W-1:0]  y_wide;
  sample_t y_val;
  logic    can_finish;

  always_comb begin
    far_v  = far_ok_r  ? rd_far  : '0;
    near_v = near_ok_r ? rd_near : '0;
    w_near = FRAC_ONE - frac_r;
    acc    = ACC_W'(p_far_r) + ACC_W'(p_near_r);
    acc_sh = acc >>> FRAC_SHIFT;
    fb_term = GTERM_W'(fb_prod_r >>> GAIN_SHIFT);
    ff_term = GTERM_W'(ff_prod_r >>> GAIN_SHIFT);
    u_wide = WIDE_W'(x_r) - WIDE_W'(fb_term);
    u_val  = saturate(u_wide);
    y_wide = WIDE_W'(u_val) + WIDE_W'(ff_term);
    y_val  = saturate(y_wide);
    can_finish = (state_r == S_DONE) && (!out_valid_r || out_ready);
    ram_we = can_finish;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      delay_length_r <= DLEN_W'(1);
      interp_frac_r  <= '0;
      ff_gain_r      <= '0;
      fb_gain_r      <= '0;
      wp_r           <= '0;
      fill_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_DELAY_LENGTH:     delay_length_r <= cfg_data[DLEN_W-1:0];
          CFG_INTERP_FRAC:      interp_frac_r  <= cfg_data[FRAC_W-1:0];
          CFG_FEEDFORWARD_GAIN: ff_gain_r      <= cfg_data[GAIN_W-1:0];
          CFG_FEEDBACK_GAIN:    fb_gain_r      <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (can_finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r         <= in_sample;
            frac_r      <= frac_clamped;
            far_addr_r  <= far_addr_nxt;
            near_addr_r <= near_addr_nxt;
            far_ok_r    <= (fill_r == CNT_W'(MAX_DELAY)) ||
                           (CNT_W'(far_addr_nxt) < fill_r);
            near_ok_r   <= (fill_r == CNT_W'(MAX_DELAY)) ||
                           (CNT_W'(near_addr_nxt) < fill_r);
            state_r     <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_INTERP;
        end
        S_INTERP: begin
          p_far_r  <= far_v  * $signed({1'b0, frac_r});
          p_near_r <= near_v * $signed({1'b0, w_near});
          state_r  <= S_SUM;
        end
        S_SUM: begin
          d_r     <= acc_sh[SAMPLE_WIDTH-1:0];
          state_r <= S_GAIN;
        end
        S_GAIN: begin
          fb_prod_r <= fb_gain_r * d_r;
          ff_prod_r <= ff_gain_r * d_r;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (can_finish) begin
            out_sample_r <= y_val;
            wp_r         <= wp_nxt;
            if (fill_r != CNT_W'(MAX_DELAY)) begin
              fill_r <= fill_r + CNT_W'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sim/fdcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcf_checker
// Watches the sample, result and register channels of the comb filter, keeps
// its own copy of the delay line and registers, predicts every filtered
// sample and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module fdcf_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  fdcf_pkg::sample_t               in_sample,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  fdcf_pkg::sample_t               out_sample,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [fdcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdcf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending
);

  import fdcf_pkg::*;

  localparam longint FRAC_FULL = 65536;
  localparam int     EXP_DEPTH = 16;

  sample_t                  delay_line [MAX_DELAY];
  addr_t                    wr_pos;
  logic [DLEN_W-1:0]        cur_len;
  logic [FRAC_W-1:0]        cur_frac;
  logic signed [GAIN_W-1:0] cur_alpha;
  logic signed [GAIN_W-1:0] cur_beta;
  sample_t                  predicted_samples [EXP_DEPTH];
  int                       exp_head;
  int                       exp_tail;
  sample_t                  want;
  int                       err_count;

  function automatic sample_t clip_sample(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return sample_t'(hi);
    end else if (v < lo) begin
      return sample_t'(lo);
    end
    return sample_t'(v);
  endfunction

  // Interpolate the two taps, apply feedback and feedforward, write back.
  function automatic sample_t filter_step(input sample_t x);
    longint len;
    longint frac;
    longint far_v;
    longint near_v;
    longint d;
    longint u;
    longint y;
    addr_t  far_a;
    addr_t  near_a;
    len = cur_len;
    if (len < 1) len = 1;
    if (len > MAX_DELAY) len = MAX_DELAY;
    frac = cur_frac;
    if (frac > FRAC_FULL) frac = FRAC_FULL;
    far_a  = wr_pos - addr_t'(len);
    near_a = wr_pos - addr_t'((len > 1) ? len - 1 : 1);
    far_v  = delay_line[far_a];
    near_v = delay_line[near_a];
    d = (far_v * frac + near_v * (FRAC_FULL - frac)) >>> FRAC_SHIFT;
    u = clip_sample(longint'(x) - ((longint'(cur_beta) * d) >>> GAIN_SHIFT));
    y = clip_sample(u + ((longint'(cur_alpha) * d) >>> GAIN_SHIFT));
    delay_line[wr_pos] = sample_t'(u);
    wr_pos = wr_pos + 1'b1;
    return sample_t'(y);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (delay_line[i]) delay_line[i] = '0;
      wr_pos    = '0;
      cur_len   = DLEN_W'(1);
      cur_frac  = '0;
      cur_alpha = '0;
      cur_beta  = '0;
      exp_head  = 0;
      exp_tail  = 0;
      err_count = 0;
      mismatches <= 0;
      pending    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DELAY_LENGTH:     cur_len   = cfg_data[DLEN_W-1:0];
          CFG_INTERP_FRAC:      cur_frac  = cfg_data[FRAC_W-1:0];
          CFG_FEEDFORWARD_GAIN: cur_alpha = cfg_data[GAIN_W-1:0];
          CFG_FEEDBACK_GAIN:    cur_beta  = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (exp_tail == exp_head) begin
          $error("out_sample: expected none, actual %0d", out_sample);
          err_count++;
        end else begin
          want = predicted_samples[exp_head % EXP_DEPTH];
          exp_head++;
          if (out_sample !== want) begin
            $error("out_sample: expected %0d, actual %0d", want, out_sample);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted_samples[exp_tail % EXP_DEPTH] = filter_step(in_sample);
        exp_tail++;
      end
      mismatches <= err_count;
      pending    <= exp_tail - exp_head;
    end
  end

endmodule

FILE: sim/tb_fractional_delay_comb_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fractional_delay_comb_filter
// Drives samples and register writes into the comb filter with random gaps
// on both sides, a long result stall and drained pauses between register
// phases; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_fractional_delay_comb_filter;
  import fdcf_pkg::*;

  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 5;
  localparam int RANDOM_ITEMS     = 1100;
  localparam int FIRST_BATCH      = 300;
  localparam int MAX_GAP          = 5;
  localparam int LONG_HOLD_AT     = 100;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 30;
  localparam int RUN_LIMIT_NS     = 2_000_000;
  localparam int MAX_DLEN_CODE    = (1 << DLEN_W) - 1;
  localparam int MAX_FRAC_CODE    = (1 << FRAC_W) - 1;
  localparam int MAX_IDX_CODE     = (1 << CFG_IDX_W) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = CFG_IDX_W'(4);

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  sample_t               in_sample;
  logic                  out_valid;
  logic                  out_ready;
  sample_t               out_sample;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    pending;
  bit                    src_no_gaps;
  bit                    sink_no_gaps;
  int                    sent_count;

  fractional_delay_comb_filter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  fdcf_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  initial begin
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  // Hold cfg_valid high across back-to-back writes; finish_cfg drops it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic finish_cfg();
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input sample_t x);
    int gap;
    gap = src_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(0, 15))
      0:       return sample_t'(16'h8000);
      1:       return sample_t'(16'h7FFF);
      2:       return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_gain();
    logic [GAIN_W-1:0] g;
    case ($urandom_range(0, 7))
      0:       g = 16'h8000;
      1:       g = 16'h7FFF;
      2:       g = '0;
      3:       g = GAIN_W'($urandom);
      default: g = GAIN_W'($urandom_range(0, 16383) - 8192);
    endcase
    return {(CFG_DATA_W-GAIN_W)'($urandom), g};
  endfunction

  task automatic random_config();
    int len;
    int frac;
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = 1;
        2:       len = MAX_DELAY;
        3:       len = $urandom_range(MAX_DELAY + 1, MAX_DLEN_CODE);
        4:       len = $urandom_range(1, MAX_DELAY);
        default: len = $urandom_range(1, 40);
      endcase
      write_reg(CFG_DELAY_LENGTH, {(CFG_DATA_W-DLEN_W)'($urandom), DLEN_W'(len)});
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 7))
        0:       frac = 0;
        1:       frac = 65536;
        2:       frac = $urandom_range(65537, MAX_FRAC_CODE);
        default: frac = $urandom_range(0, 65535);
      endcase
      write_reg(CFG_INTERP_FRAC, CFG_DATA_W'(frac));
    end
    if ($urandom_range(0, 1)) write_reg(CFG_FEEDFORWARD_GAIN, random_gain());
    if ($urandom_range(0, 1)) write_reg(CFG_FEEDBACK_GAIN, random_gain());
    if ($urandom_range(0, 7) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_INDEX, MAX_IDX_CODE)),
                CFG_DATA_W'($urandom));
    end
    finish_cfg();
  endtask

  // Result side: random stalls per transfer, one long hold-off.
  initial begin : result_sink
    int hold_left;
    int got;
    out_ready <= 1'b0;
    hold_left = 0;
    got = 0;
    sink_no_gaps = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got++;
        if (got % 64 == 0) sink_no_gaps = ($urandom_range(0, 3) == 0);
        if (got == LONG_HOLD_AT) begin
          hold_left = LONG_HOLD_CYCLES;
        end else begin
          hold_left = sink_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (hold_left > 0) out_ready <= 1'b0;
      end else if (!out_ready) begin
        hold_left--;
        if (hold_left <= 0) out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int batch;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    sent_count = 0;
    src_no_gaps = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // delay of one, most negative feedback gain, saturating extremes
    write_reg(CFG_DELAY_LENGTH, CFG_DATA_W'(1));
    write_reg(CFG_INTERP_FRAC, CFG_DATA_W'(0));
    write_reg(CFG_FEEDFORWARD_GAIN, CFG_DATA_W'(16'h7FFF));
    write_reg(CFG_FEEDBACK_GAIN, CFG_DATA_W'(16'h8000));
    finish_cfg();
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(16'h8000));
    send_sample('0);
    send_sample(sample_t'(16'hFFFF));
    send_sample(sample_t'(16'h0001));
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(16'h8000));
    in_valid <= 1'b0;
    wait_drained();

    // zero delay, fraction above one, ignored index
    write_reg(CFG_DELAY_LENGTH, CFG_DATA_W'(0));
    write_reg(CFG_INTERP_FRAC, CFG_DATA_W'(MAX_FRAC_CODE));
    write_reg(CFG_FEEDFORWARD_GAIN, CFG_DATA_W'(17'h18000));
    write_reg(CFG_FEEDBACK_GAIN, CFG_DATA_W'(16'h7FFF));
    write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'(MAX_FRAC_CODE));
    finish_cfg();
    src_no_gaps = 1'b1;
    send_sample(sample_t'(16'h8000));
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(12345));
    send_sample(sample_t'(16'hFFFF));
    send_sample('0);
    send_sample(sample_t'(16384));
    in_valid <= 1'b0;
    wait_drained();

    // delay above the store depth, fraction of exactly one
    write_reg(CFG_DELAY_LENGTH, CFG_DATA_W'(MAX_FRAC_CODE));
    write_reg(CFG_INTERP_FRAC, CFG_DATA_W'(65536));
    write_reg(CFG_FEEDFORWARD_GAIN, CFG_DATA_W'(16384));
    write_reg(CFG_FEEDBACK_GAIN, CFG_DATA_W'(0));
    finish_cfg();
    src_no_gaps = 1'b0;
    send_sample(sample_t'(100));
    send_sample(sample_t'(-100));
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(16'h8000));
    in_valid <= 1'b0;
    wait_drained();

    // shorten the delay with no flush, half-way interpolation
    write_reg(CFG_DELAY_LENGTH, CFG_DATA_W'(2));
    write_reg(CFG_INTERP_FRAC, CFG_DATA_W'(32768));
    write_reg(CFG_FEEDFORWARD_GAIN, CFG_DATA_W'(16'hC000));
    write_reg(CFG_FEEDBACK_GAIN, CFG_DATA_W'(8192));
    finish_cfg();
    send_sample(sample_t'(1000));
    send_sample(sample_t'(-2000));
    send_sample(sample_t'(3000));
    send_sample('0);
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(16'h8000));
    in_valid <= 1'b0;
    wait_drained();

    while (sent_count < RANDOM_ITEMS) begin
      random_config();
      if (sent_count == 0) begin
        batch = FIRST_BATCH;
      end else if ($urandom_range(0, 9) == 0) begin
        batch = $urandom_range(150, 300);
      end else begin
        batch = $urandom_range(10, 80);
      end
      if (batch > RANDOM_ITEMS - sent_count) batch = RANDOM_ITEMS - sent_count;
      src_no_gaps = ($urandom_range(0, 3) == 0);
      repeat (batch) begin
        send_sample(random_sample());
        sent_count++;
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
